// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define SFSD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds during reset.
`define SFSD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/sfsd_pkg.sv -----
package sfsd_pkg;

    localparam int MAX_NODES     = 128;
    localparam int MAX_TERMINALS = 10;
    localparam int MAX_EDGES     = 2048;
    localparam int COST_WIDTH    = 32;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int SUB_W    = MAX_TERMINALS;
    localparam int NSUB     = 1 << SUB_W;
    localparam int PAIR_W   = MAX_TERMINALS / 2;
    localparam int NPAIRSUB = 1 << PAIR_W;
    localparam int NENTRY   = 2 * MAX_EDGES;
    localparam int ENTRY_W  = $clog2(NENTRY);
    localparam int PTR_W    = ENTRY_W + 1;
    localparam int NCNT_W   = 8;
    localparam int TCNT_W   = 4;
    localparam int WEIGHT_W = 16;
    localparam int DADDR_W  = NODE_W + SUB_W;

    localparam logic [COST_WIDTH-1:0] INF = COST_WIDTH'(32'h3f3f3f3f);

    typedef struct packed {
        logic [NODE_W-1:0]   to;
        logic [PTR_W-1:0]    next;
        logic [WEIGHT_W-1:0] wt;
    } entry_t;

    typedef enum logic [1:0] {
        REG_NODE_COUNT     = 2'd0,
        REG_TERMINAL_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LD_RA, S_LD_WA, S_LD_RB, S_LD_WB,
        S_SOLVE, S_MRG_START, S_MRG_RD, S_MRG_CMP, S_MRG_WR,
        S_RLX_POP, S_RLX_HEAD, S_RLX_LINK, S_RLX_EDGE, S_RLX_DST, S_RLX_UPD,
        S_BST_RD, S_BST_CMP,
        S_PR_START, S_PR_SUB, S_PR_RD, S_PR_CMP, S_PR_WR,
        S_FIN
    } state_t;

    function automatic logic [COST_WIDTH-1:0] sat_add(input logic [COST_WIDTH-1:0] a,
                                                      input logic [COST_WIDTH-1:0] b);
        logic [COST_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, INF}) ? INF : s[COST_WIDTH-1:0];
    endfunction

    // Spread each pair bit over its two terminal bits.
    function automatic logic [SUB_W-1:0] pair_mask(input logic [PAIR_W-1:0] t);
        logic [SUB_W-1:0] m;
        m = '0;
        for (int i = 0; i < PAIR_W; i++) begin
            m[2*i]   = t[i];
            m[2*i+1] = t[i];
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/steiner_forest_subset_dp.sv -----
// Steiner forest over terminal pairs, subset DP with queue relaxation.
// Input stream (s_*): one undirected edge per beat; tlast marks the final
// edge of a graph and starts the solve. A stored edge is accepted, then
// written as two adjacency entries, each a head read then a write; a
// dropped edge is only accepted.
// Config channel (cfg_*): index 0 node_count, 1 terminal_count; always ready,
// write only while idle.
// Result stream (m_*): one beat per tlast edge with total_cost and found.
// Solve time is data dependent and set by the single dist memory sequencer,
// which steps through the submask pairs of each node in the merges, the
// adjacency entries scanned in relaxation (no dist read when the far end is
// beyond node_count) and the queue pops, the nodes in the minimum scan and the
// submasks in the pair DP. s_tready is low for the whole solve.
// The result sits in an output register; the next graph may load while it
// waits, but a new solve holds in its final state until the old beat is taken.
// Reset (aresetn low, synchronous) empties the edge store, restores
// node_count 128 and terminal_count 2 and drops any pending result.
// No clearing pass: dist entries are always written before they are read.
module steiner_forest_subset_dp
    import sfsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // end_a[7:0], end_b[15:8], weight[31:16]
    input  logic        s_tlast,   // last_edge
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // total_cost[31:0], found[32], zero[39:33]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    state_t state_reg, state_next;
    logic [NCNT_W-1:0]     nc_reg, nc_next;
    logic [TCNT_W-1:0]     tc_reg, tc_next;
    logic [PTR_W-1:0]      ec_reg, ec_next;
    logic [MAX_NODES-1:0]  hv_reg, hv_next;
    logic [MAX_NODES-1:0]  mark_reg, mark_next;
    logic [NODE_W-1:0]     qhead_reg, qhead_next;
    logic [NODE_W:0]       qlen_reg, qlen_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [NODE_W-1:0]     a_reg, a_next, b_reg, b_next, y_reg, y_next;
    logic [WEIGHT_W-1:0]   w_reg, w_next, ew_reg, ew_next;
    logic                  last_reg, last_next;
    logic [SUB_W-1:0]      s_reg, s_next, t_reg, t_next;
    logic [NODE_W:0]       i_reg, i_next;
    logic [COST_WIDTH-1:0] cur_reg, cur_next, dx_reg, dx_next;
    logic [PTR_W-1:0]      e_reg, e_next;
    logic [PAIR_W-1:0]     ps_reg, ps_next, pt_reg, pt_next;
    logic [31:0]           m_cost_reg, m_cost_next;
    logic                  m_found_reg, m_found_next;

    // Memories
    logic [PTR_W-1:0]      head_mem [MAX_NODES];
    entry_t                edge_mem [NENTRY];
    logic [COST_WIDTH-1:0] dist_mem [MAX_NODES*NSUB];
    logic [COST_WIDTH-1:0] best_mem [NSUB];
    logic [COST_WIDTH-1:0] pair_mem [NPAIRSUB];
    logic [NODE_W-1:0]     queue_mem [MAX_NODES];

    logic                  head_we;
    logic [NODE_W-1:0]     head_waddr, head_raddr;
    logic [PTR_W-1:0]      head_wdata, head_q;
    logic                  head_qv;
    logic                  edge_we;
    logic [ENTRY_W-1:0]    edge_waddr, edge_raddr;
    entry_t                edge_wdata, edge_q;
    logic                  dist_we;
    logic [DADDR_W-1:0]    dist_waddr, dist_raddr_a, dist_raddr_b;
    logic [COST_WIDTH-1:0] dist_wdata, dista_q, distb_q;
    logic                  best_we;
    logic [SUB_W-1:0]      best_waddr, best_raddr;
    logic [COST_WIDTH-1:0] best_wdata, best_q;
    logic                  pair_we;
    logic [PAIR_W-1:0]     pair_waddr, pair_raddr;
    logic [COST_WIDTH-1:0] pair_wdata, pair_q;
    logic                  pair_zero_q;
    logic                  push_en, push_ok, pop_en, clr_en;
    logic [NODE_W-1:0]     push_node;
    logic [NODE_W-1:0]     queue_q;

    // Effective sizes
    logic [NCNT_W-1:0]     n_eff;
    logic [TCNT_W-1:0]     k_eff;
    logic [SUB_W-1:0]      full;
    logic [PAIR_W-1:0]     pfull;
    logic [COST_WIDTH-1:0] c_sum;
    logic [7:0]            in_a, in_b;
    logic                  in_ok;

    assign n_eff = (nc_reg > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : nc_reg;
    assign k_eff = (tc_reg > TCNT_W'(MAX_TERMINALS)) ? TCNT_W'(MAX_TERMINALS) : tc_reg;
    assign full  = SUB_W'(((SUB_W+1)'(1) << k_eff) - (SUB_W+1)'(1));
    assign pfull = PAIR_W'(((PAIR_W+1)'(1) << (k_eff >> 1)) - (PAIR_W+1)'(1));

    assign in_a  = s_tdata[7:0];
    assign in_b  = s_tdata[15:8];
    assign in_ok = (in_a != 8'd0) && (in_a <= 8'(MAX_NODES)) &&
                   (in_b != 8'd0) && (in_b <= 8'(MAX_NODES)) &&
                   (({1'b0, ec_reg} + (PTR_W+1)'(2)) <= (PTR_W+1)'(NENTRY));

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_found_reg, m_cost_reg};

    // Queue push only for nodes not already queued, while the queue has room.
    assign push_ok = push_en && !mark_reg[push_node] && (qlen_reg < (NODE_W+1)'(MAX_NODES));

    always_comb begin
        state_next    = state_reg;
        nc_next       = nc_reg;
        tc_next       = tc_reg;
        ec_next       = ec_reg;
        hv_next       = hv_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        a_next = a_reg; b_next = b_reg; w_next = w_reg; last_next = last_reg;
        y_next = y_reg; ew_next = ew_reg;
        s_next = s_reg; t_next = t_reg; i_next = i_reg;
        cur_next = cur_reg; dx_next = dx_reg; e_next = e_reg;
        ps_next = ps_reg; pt_next = pt_reg;
        m_cost_next = m_cost_reg; m_found_next = m_found_reg;

        head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
        edge_we = 1'b0; edge_waddr = '0; edge_wdata = '0; edge_raddr = '0;
        dist_we = 1'b0; dist_waddr = '0; dist_wdata = '0;
        dist_raddr_a = '0; dist_raddr_b = '0;
        best_we = 1'b0; best_waddr = '0; best_wdata = '0; best_raddr = '0;
        pair_we = 1'b0; pair_waddr = '0; pair_wdata = '0; pair_raddr = '0;
        push_en = 1'b0; push_node = '0; pop_en = 1'b0; clr_en = 1'b0;
        c_sum = '0;

        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_NODE_COUNT:     nc_next = cfg_data;
                REG_TERMINAL_COUNT: tc_next = cfg_data[TCNT_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    a_next    = NODE_W'(in_a - 8'd1);
                    b_next    = NODE_W'(in_b - 8'd1);
                    w_next    = s_tdata[31:16];
                    last_next = s_tlast;
                    if (in_ok)        state_next = S_LD_RA;
                    else if (s_tlast) state_next = S_SOLVE;
                end
            end
            S_LD_RA: begin
                head_raddr = a_reg;
                state_next = S_LD_WA;
            end
            S_LD_WA: begin
                edge_we    = 1'b1;
                edge_waddr = ec_reg[ENTRY_W-1:0];
                edge_wdata = '{to: b_reg, next: (head_qv ? head_q : '0), wt: w_reg};
                head_we    = 1'b1;
                head_waddr = a_reg;
                head_wdata = ec_reg + PTR_W'(1);
                hv_next[a_reg] = 1'b1;
                ec_next    = ec_reg + PTR_W'(1);
                state_next = S_LD_RB;
            end
            S_LD_RB: begin
                head_raddr = b_reg;
                state_next = S_LD_WB;
            end
            S_LD_WB: begin
                edge_we    = 1'b1;
                edge_waddr = ec_reg[ENTRY_W-1:0];
                edge_wdata = '{to: a_reg, next: (head_qv ? head_q : '0), wt: w_reg};
                head_we    = 1'b1;
                head_waddr = b_reg;
                head_wdata = ec_reg + PTR_W'(1);
                hv_next[b_reg] = 1'b1;
                ec_next    = ec_reg + PTR_W'(1);
                state_next = last_reg ? S_SOLVE : S_IDLE;
            end
            S_SOLVE: begin
                s_next     = SUB_W'(1);
                i_next     = '0;
                state_next = (full == '0) ? S_PR_START : S_MRG_START;
            end
            S_MRG_START: begin
                if (i_reg == n_eff) begin
                    state_next = S_RLX_POP;
                end else begin
                    cur_next = ((i_reg < (NODE_W+1)'(k_eff)) &&
                                (s_reg == (SUB_W'(1) << i_reg))) ? '0 : INF;
                    t_next   = (s_reg - SUB_W'(1)) & s_reg;
                    state_next = (((s_reg - SUB_W'(1)) & s_reg) == '0) ? S_MRG_WR : S_MRG_RD;
                end
            end
            S_MRG_RD: begin
                dist_raddr_a = {i_reg[NODE_W-1:0], t_reg};
                dist_raddr_b = {i_reg[NODE_W-1:0], s_reg ^ t_reg};
                state_next   = S_MRG_CMP;
            end
            S_MRG_CMP: begin
                c_sum = sat_add(dista_q, distb_q);
                if (c_sum < cur_reg) cur_next = c_sum;
                t_next = (t_reg - SUB_W'(1)) & s_reg;
                state_next = (((t_reg - SUB_W'(1)) & s_reg) == '0) ? S_MRG_WR : S_MRG_RD;
            end
            S_MRG_WR: begin
                dist_we    = 1'b1;
                dist_waddr = {i_reg[NODE_W-1:0], s_reg};
                dist_wdata = cur_reg;
                push_en    = (cur_reg != INF);
                push_node  = i_reg[NODE_W-1:0];
                i_next     = i_reg + (NODE_W+1)'(1);
                state_next = S_MRG_START;
            end
            S_RLX_POP: begin
                if (qlen_reg == '0) begin
                    i_next     = '0;
                    cur_next   = INF;
                    state_next = S_BST_RD;
                end else begin
                    pop_en     = 1'b1;
                    state_next = S_RLX_HEAD;
                end
            end
            S_RLX_HEAD: begin
                clr_en       = 1'b1;
                head_raddr   = queue_q;
                dist_raddr_a = {queue_q, s_reg};
                state_next   = S_RLX_LINK;
            end
            S_RLX_LINK: begin
                e_next     = head_qv ? head_q : '0;
                dx_next    = dista_q;
                state_next = S_RLX_EDGE;
            end
            S_RLX_EDGE: begin
                if ((e_reg == '0) || (e_reg > ec_reg)) begin
                    state_next = S_RLX_POP;
                end else begin
                    edge_raddr = ENTRY_W'(e_reg - PTR_W'(1));
                    state_next = S_RLX_DST;
                end
            end
            S_RLX_DST: begin
                y_next  = edge_q.to;
                ew_next = edge_q.wt;
                e_next  = edge_q.next;
                if ((NCNT_W'(edge_q.to)) < n_eff) begin
                    dist_raddr_a = {edge_q.to, s_reg};
                    state_next   = S_RLX_UPD;
                end else begin
                    state_next = S_RLX_EDGE;
                end
            end
            S_RLX_UPD: begin
                c_sum = sat_add(dx_reg, COST_WIDTH'(ew_reg));
                if (dista_q > c_sum) begin
                    dist_we    = 1'b1;
                    dist_waddr = {y_reg, s_reg};
                    dist_wdata = c_sum;
                    push_en    = 1'b1;
                    push_node  = y_reg;
                end
                state_next = S_RLX_EDGE;
            end
            S_BST_RD: begin
                if (i_reg == n_eff) begin
                    best_we    = 1'b1;
                    best_waddr = s_reg;
                    best_wdata = cur_reg;
                    i_next     = '0;
                    s_next     = s_reg + SUB_W'(1);
                    state_next = (s_reg == full) ? S_PR_START : S_MRG_START;
                end else begin
                    dist_raddr_a = {i_reg[NODE_W-1:0], s_reg};
                    state_next   = S_BST_CMP;
                end
            end
            S_BST_CMP: begin
                if (dista_q < cur_reg) cur_next = dista_q;
                i_next     = i_reg + (NODE_W+1)'(1);
                state_next = S_BST_RD;
            end
            S_PR_START: begin
                if (pfull == '0) begin
                    cur_next   = '0;
                    state_next = S_FIN;
                end else begin
                    ps_next    = PAIR_W'(1);
                    state_next = S_PR_SUB;
                end
            end
            S_PR_SUB: begin
                cur_next   = INF;
                pt_next    = ps_reg;
                state_next = S_PR_RD;
            end
            S_PR_RD: begin
                pair_raddr = ps_reg ^ pt_reg;
                best_raddr = pair_mask(pt_reg);
                state_next = S_PR_CMP;
            end
            S_PR_CMP: begin
                c_sum = sat_add(pair_zero_q ? '0 : pair_q, best_q);
                if (c_sum < cur_reg) cur_next = c_sum;
                pt_next = (pt_reg - PAIR_W'(1)) & ps_reg;
                state_next = (((pt_reg - PAIR_W'(1)) & ps_reg) == '0) ? S_PR_WR : S_PR_RD;
            end
            S_PR_WR: begin
                pair_we    = 1'b1;
                pair_waddr = ps_reg;
                pair_wdata = cur_reg;
                ps_next    = ps_reg + PAIR_W'(1);
                state_next = (ps_reg == pfull) ? S_FIN : S_PR_SUB;
            end
            S_FIN: begin
                // hold until the previous result beat is gone
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = (cur_reg != INF);
                    m_cost_next   = (cur_reg != INF) ? 32'(cur_reg) : 32'd0;
                    hv_next       = '0;
                    ec_next       = '0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Queue bookkeeping
    always_comb begin
        mark_next  = mark_reg;
        qhead_next = qhead_reg;
        qlen_next  = qlen_reg;
        if (clr_en) mark_next[queue_q] = 1'b0;
        if (push_ok) begin
            mark_next[push_node] = 1'b1;
            qlen_next = qlen_next + (NODE_W+1)'(1);
        end
        if (pop_en) begin
            qhead_next = qhead_reg + NODE_W'(1);
            qlen_next  = qlen_next - (NODE_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nc_reg       <= NCNT_W'(128);
            tc_reg       <= TCNT_W'(2);
            ec_reg       <= '0;
            hv_reg       <= '0;
            mark_reg     <= '0;
            qhead_reg    <= '0;
            qlen_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nc_reg       <= nc_next;
            tc_reg       <= tc_next;
            ec_reg       <= ec_next;
            hv_reg       <= hv_next;
            mark_reg     <= mark_next;
            qhead_reg    <= qhead_next;
            qlen_reg     <= qlen_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next; b_reg <= b_next; w_reg <= w_next; last_reg <= last_next;
        y_reg <= y_next; ew_reg <= ew_next;
        s_reg <= s_next; t_reg <= t_next; i_reg <= i_next;
        cur_reg <= cur_next; dx_reg <= dx_next; e_reg <= e_next;
        ps_reg <= ps_next; pt_reg <= pt_next;
        m_cost_reg <= m_cost_next; m_found_reg <= m_found_next;
    end

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_waddr] <= head_wdata;
        head_q  <= head_mem[head_raddr];
        head_qv <= hv_reg[head_raddr];
    end

    always_ff @(posedge aclk) begin
        if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
        edge_q <= edge_mem[edge_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
        dista_q <= dist_mem[dist_raddr_a];
        distb_q <= dist_mem[dist_raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (best_we) best_mem[best_waddr] <= best_wdata;
        best_q <= best_mem[best_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
        pair_q      <= pair_mem[pair_raddr];
        pair_zero_q <= (pair_raddr == '0);
    end

    always_ff @(posedge aclk) begin
        if (push_ok) queue_mem[qhead_reg + qlen_reg[NODE_W-1:0]] <= push_node;
        queue_q <= queue_mem[qhead_reg];
    end

endmodule

// ----- rtl/core/sfsd_checker.sv -----
`include "assert_macros.svh"

module sfsd_checker
    import sfsd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `SFSD_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `SFSD_ASSERT(a_nf_zero, aclk, aresetn, m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0, "cost nonzero on a not-found result")
    `SFSD_ASSERT(a_cost_fin, aclk, aresetn, m_tvalid && m_tdata[32] |-> m_tdata[31:0] < 32'(INF), "found result carries unreachable cost")
    `SFSD_ASSERT(a_busy, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready), "result appeared without a solve")
    `SFSD_ASSERT_NR(a_rst, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind steiner_forest_subset_dp sfsd_checker u_sfsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
